@@ rtl/min_tracking_stack_macros.svh @@
// Assertion macros used by the checker file.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_tracking_stack check failed");

// Next-cycle implication, disabled while reset is held.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_tracking_stack check failed");

`endif

@@ rtl/mts_pkg.sv @@
`timescale 1ns / 1ps
package mts_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;

    localparam logic [1:0] REQ_PUSH  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_POP_EMPTY = 2'd1;
    localparam logic [1:0] ERR_PUSH_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_RESP = 3'b100
    } t_state;

    typedef struct packed {
        logic push;
        logic pop;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic one;
    } t_dp_sts;

endpackage

@@ rtl/mts_datapath.sv @@
`timescale 1ns / 1ps
module mts_datapath import mts_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_push_value,
    output t_dp_sts            o_sts,
    output logic signed [31:0] o_top_value,
    output logic signed [31:0] o_min_value,
    output logic [6:0]         o_element_count
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    // Top entry lives in registers; the memory holds the entries below it.
    logic signed [31:0] r_top;
    logic signed [31:0] r_min;
    logic [CW-1:0]      r_count;
    logic signed [31:0] r_rd_top;
    logic signed [31:0] r_rd_min;
    logic signed [31:0] mem_top [STACK_DEPTH];
    logic signed [31:0] mem_min [STACK_DEPTH];

    logic [CW-1:0]      w_count_m1;
    logic [CW-1:0]      w_count_m2;
    logic [AW-1:0]      w_wr_addr;
    logic [AW-1:0]      w_rd_addr;
    logic signed [31:0] n_min;
    logic [CW+6:0]      w_count_ext;

    assign w_count_m1 = r_count - CW'(1);
    assign w_count_m2 = r_count - CW'(2);
    assign w_wr_addr  = w_count_m1[AW-1:0];
    assign w_rd_addr  = w_count_m2[AW-1:0];

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == CW'(STACK_DEPTH));
    assign o_sts.one   = (r_count == CW'(1));

    always_comb begin
        if (o_sts.empty || (i_push_value < r_min)) begin
            n_min = i_push_value;
        end else begin
            n_min = r_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_count <= w_count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= i_push_value;
            r_min <= n_min;
        end else if (i_cmd.load) begin
            r_top <= r_rd_top;
            r_min <= r_rd_min;
        end
    end

    // Spill the old top below the new one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !o_sts.empty) begin
            mem_top[w_wr_addr] <= r_top;
            mem_min[w_wr_addr] <= r_min;
        end
    end

    // Keep the entry under the top read out through a register addressed from the count.
    always_ff @(posedge i_clk) begin
        r_rd_top <= mem_top[w_rd_addr];
        r_rd_min <= mem_min[w_rd_addr];
    end

    assign w_count_ext     = {7'b0, r_count};
    assign o_element_count = w_count_ext[6:0];
    assign o_top_value     = o_sts.empty ? 32'sd0 : r_top;
    assign o_min_value     = o_sts.empty ? 32'sd0 : r_min;

endmodule

@@ rtl/mts_ctrl.sv @@
`timescale 1ns / 1ps
module mts_ctrl import mts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  logic       i_out_stall,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic [1:0] o_error_code
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_err;
    logic [1:0] n_err;
    logic       w_accept;

    assign w_accept    = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign o_error_code = r_err;

    assign o_cmd.push = w_accept && (i_req_type == REQ_PUSH) && !i_sts.full;
    assign o_cmd.pop  = w_accept && (i_req_type == REQ_POP) && !i_sts.empty;
    assign o_cmd.load = (r_state == S_POP);

    always_comb begin
        n_err = r_err;
        if (w_accept) begin
            n_err = ERR_OK;
            if ((i_req_type == REQ_PUSH) && i_sts.full) begin
                n_err = ERR_PUSH_FULL;
            end else if ((i_req_type == REQ_POP) && i_sts.empty) begin
                n_err = ERR_POP_EMPTY;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // A pop that leaves entries behind waits for the memory read.
                    n_state = (o_cmd.pop && !i_sts.one) ? S_POP : S_RESP;
                end
            end
            S_POP: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= ERR_OK;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

endmodule

@@ rtl/min_tracking_stack.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_stall    i_req_type, i_push_value
// result    out        o_out_valid / i_out_stall  o_top_value, o_min_value,
//                                                 o_element_count, o_is_empty, o_error_code
//
// A push, a query or a failed request shows its result in the cycle after the transfer in;
// a pop that leaves the stack non-empty first waits in S_POP for the registered read
// of the stack memory. The next request is taken the cycle after the result transfers.
// Synchronous reset empties the stack; stack memory contents are not cleared.
// The result holds, and requests stall, for as long as i_out_stall is high.
module min_tracking_stack import mts_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_push_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_top_value,
    output logic signed [31:0] o_min_value,
    output logic [6:0]         o_element_count,
    output logic               o_is_empty,
    output logic [1:0]         o_error_code
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mts_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_req_type   (i_req_type),
        .i_out_stall  (i_out_stall),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_error_code (o_error_code)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_push_value    (i_push_value),
        .o_sts           (w_sts),
        .o_top_value     (o_top_value),
        .o_min_value     (o_min_value),
        .o_element_count (o_element_count)
    );

    assign o_is_empty = w_sts.empty;

endmodule

@@ rtl/mts_checker.sv @@
`timescale 1ns / 1ps
`include "min_tracking_stack_macros.svh"
module mts_checker import mts_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_top_value,
    input logic signed [31:0] o_min_value,
    input logic [6:0]         o_element_count,
    input logic               o_is_empty,
    input logic [1:0]         o_error_code
);

    // An empty stack reports zero for both words.
    `MTS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n,
        o_out_valid && o_is_empty,
        (o_top_value == 32'sd0) && (o_min_value == 32'sd0))

    // The minimum never exceeds the top word.
    `MTS_ASSERT_NOW(a_min_le_top, i_clk, i_rst_n,
        o_out_valid && !o_is_empty,
        o_min_value <= o_top_value)

    // A failed pop only happens on an empty stack.
    `MTS_ASSERT_NOW(a_pop_err_empty, i_clk, i_rst_n,
        o_out_valid && (o_error_code == ERR_POP_EMPTY),
        o_is_empty)

    // No request is taken while a result is pending.
    `MTS_ASSERT_NOW(a_one_in_flight, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // A stalled result holds.
    `MTS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_top_value) && $stable(o_min_value)
            && $stable(o_element_count) && $stable(o_error_code))

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);
